[sv/vmar_pkg.sv]
// ----------------------------------------------------------------------------
// vmar_pkg
// Shared types and codes of the address range table: request and status
// codes, register indexes, and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package vmar_pkg;

  localparam int FIELD_W = 36;
  localparam int CFG_IDX_W = 1;

  localparam logic [FIELD_W-1:0] USER_LOW_RST  = 36'd16;
  localparam logic [FIELD_W-1:0] USER_HIGH_RST = 36'h8_0000_0000;

  localparam logic [CFG_IDX_W-1:0] CFG_USER_LOW  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_USER_HIGH = 1'd1;

  typedef enum logic [2:0] {
    REQ_FIND   = 3'd0,
    REQ_MAP    = 3'd1,
    REQ_LOOKUP = 3'd2,
    REQ_REMOVE = 3'd3,
    REQ_EMPTY  = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FIT   = 2'd1,
    ST_FULL     = 2'd2,
    ST_UNMAPPED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    M_GAP  = 3'd0,
    M_OVL  = 3'd1,
    M_LOOK = 3'd2,
    M_CUT  = 3'd3,
    M_INS  = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    K_OK    = 3'd0,
    K_ST1   = 3'd1,
    K_ST2   = 3'd2,
    K_ST3   = 3'd3,
    K_FOUND = 3'd4,
    K_MAP   = 3'd5,
    K_LOOK  = 3'd6,
    K_EMPTY = 3'd7
  } kind_t;

  typedef struct packed {
    logic  load;
    logic  scan;
    mode_t mode;
    logic  from_scr;
    logic  ex;
    logic  tail;
    logic  commit;
    logic  deliver;
    kind_t kind;
  } cmd_t;

  typedef struct packed {
    logic [2:0] typ;
    mode_t      mode;
    logic       np_zero;
    logic       page_zero;
    logic       fixed;
    logic       far;
    logic       at_end;
    logic       ex_hit;
    logic       ex_more;
    logic       hit;
    logic       full_act;
    logic       full_scr;
    logic       out_free;
  } sts_t;

endpackage

[sv/vmar_if.sv]
// ----------------------------------------------------------------------------
// vmar_in_if / vmar_out_if
// Valid/ready channels of the address range table: request beats in,
// result beats out.
// ----------------------------------------------------------------------------
interface vmar_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [35:0] page;
  logic [35:0] npages;
  logic        search_dir;
  logic [2:0]  prot_bits;
  logic [1:0]  map_flags;
  logic [35:0] offset_pages;

  modport source (output valid, req_type, page, npages, search_dir, prot_bits,
                  map_flags, offset_pages, input ready);
  modport sink (input valid, req_type, page, npages, search_dir, prot_bits,
                map_flags, offset_pages, output ready);
endinterface

interface vmar_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [35:0] page_result;
  logic [35:0] area_end;
  logic [35:0] area_offset;
  logic [2:0]  area_prot;
  logic        area_shared;
  logic        range_empty;

  modport source (output valid, status, page_result, area_end, area_offset,
                  area_prot, area_shared, range_empty, input ready);
  modport sink (input valid, status, page_result, area_end, area_offset,
                area_prot, area_shared, range_empty, output ready);
endinterface

[sv/vmar_ctrl.sv]
// ----------------------------------------------------------------------------
// vmar_ctrl
// Request sequencer: picks the table passes a request needs, steps each
// pass entry by entry and chooses the result.
// ----------------------------------------------------------------------------
module vmar_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  vmar_pkg::sts_t  sts,
  output vmar_pkg::cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DISP = 6'b000010,
    S_RD   = 6'b000100,
    S_EX   = 6'b001000,
    S_TAIL = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t          state_r, state_nxt;
  vmar_pkg::kind_t kind_r, kind_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= vmar_pkg::K_OK;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.mode  = vmar_pkg::M_GAP;
    cmd.kind  = vmar_pkg::K_OK;
    state_nxt = state_r;
    kind_nxt  = kind_r;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_RD;
        case (sts.typ)
          vmar_pkg::REQ_FIND: begin
            if (sts.np_zero) begin
              kind_nxt  = vmar_pkg::K_ST1;
              state_nxt = S_DONE;
            end else begin
              cmd.scan = 1'b1;
              cmd.mode = vmar_pkg::M_GAP;
            end
          end
          vmar_pkg::REQ_MAP: begin
            if (sts.np_zero || (!sts.page_zero && sts.far)) begin
              kind_nxt  = vmar_pkg::K_ST1;
              state_nxt = S_DONE;
            end else begin
              cmd.scan = 1'b1;
              if (sts.page_zero) cmd.mode = vmar_pkg::M_GAP;
              else if (sts.fixed) cmd.mode = vmar_pkg::M_CUT;
              else cmd.mode = vmar_pkg::M_OVL;
            end
          end
          vmar_pkg::REQ_LOOKUP: begin
            cmd.scan = 1'b1;
            cmd.mode = vmar_pkg::M_LOOK;
          end
          vmar_pkg::REQ_REMOVE: begin
            if (sts.np_zero) begin
              kind_nxt  = vmar_pkg::K_OK;
              state_nxt = S_DONE;
            end else begin
              cmd.scan = 1'b1;
              cmd.mode = vmar_pkg::M_CUT;
            end
          end
          vmar_pkg::REQ_EMPTY: begin
            if (sts.np_zero) begin
              kind_nxt  = vmar_pkg::K_EMPTY;
              state_nxt = S_DONE;
            end else begin
              cmd.scan = 1'b1;
              cmd.mode = vmar_pkg::M_OVL;
            end
          end
          default: begin
            kind_nxt  = vmar_pkg::K_OK;
            state_nxt = S_DONE;
          end
        endcase
      end
      S_RD: begin
        if (sts.at_end) begin
          cmd.tail  = 1'b1;
          state_nxt = S_TAIL;
        end else begin
          state_nxt = S_EX;
        end
      end
      S_EX: begin
        cmd.ex = 1'b1;
        if (sts.ex_hit) state_nxt = S_TAIL;
        else if (sts.ex_more) state_nxt = S_EX;
        else state_nxt = S_RD;
      end
      S_TAIL: begin
        state_nxt = S_DONE;
        case (sts.typ)
          vmar_pkg::REQ_FIND: begin
            kind_nxt = sts.hit ? vmar_pkg::K_FOUND : vmar_pkg::K_ST1;
          end
          vmar_pkg::REQ_MAP: begin
            case (sts.mode)
              vmar_pkg::M_GAP, vmar_pkg::M_OVL: begin
                if ((sts.mode == vmar_pkg::M_GAP) != sts.hit) begin
                  kind_nxt = vmar_pkg::K_ST1;
                end else if (sts.full_act) begin
                  kind_nxt = vmar_pkg::K_ST2;
                end else begin
                  cmd.scan  = 1'b1;
                  cmd.mode  = vmar_pkg::M_INS;
                  state_nxt = S_RD;
                end
              end
              vmar_pkg::M_CUT: begin
                if (sts.hit || sts.full_scr) begin
                  kind_nxt = vmar_pkg::K_ST2;
                end else begin
                  cmd.scan     = 1'b1;
                  cmd.mode     = vmar_pkg::M_INS;
                  cmd.from_scr = 1'b1;
                  state_nxt    = S_RD;
                end
              end
              default: begin
                cmd.commit = 1'b1;
                kind_nxt   = vmar_pkg::K_MAP;
              end
            endcase
          end
          vmar_pkg::REQ_LOOKUP: begin
            kind_nxt = sts.hit ? vmar_pkg::K_LOOK : vmar_pkg::K_ST3;
          end
          vmar_pkg::REQ_REMOVE: begin
            if (sts.hit) begin
              kind_nxt = vmar_pkg::K_ST2;
            end else begin
              cmd.commit = 1'b1;
              kind_nxt   = vmar_pkg::K_OK;
            end
          end
          vmar_pkg::REQ_EMPTY: kind_nxt = vmar_pkg::K_EMPTY;
          default: kind_nxt = vmar_pkg::K_OK;
        endcase
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.deliver = 1'b1;
          cmd.kind    = kind_r;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_ex_only_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EX) |-> ($past(state_r) == S_RD || $past(state_r) == S_EX))
    else $error("step without a table read");
  a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_DISP))
    else $error("load did not move to dispatch");
  a_commit_before_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> (state_r == S_DONE))
    else $error("commit outside the final pass");

endmodule

[sv/vmar_dp.sv]
// ----------------------------------------------------------------------------
// vmar_dp
// Datapath: two-bank area table memory, request registers, window
// registers, gap/overlap/lookup step logic, cut and insert copy logic and
// the result register.
// ----------------------------------------------------------------------------
module vmar_dp #(
  parameter int MAX_AREAS     = 16,
  parameter int PAGE_NUM_BITS = 36
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  vmar_pkg::cmd_t                       cmd,
  output vmar_pkg::sts_t                       sts,
  input  logic                                 cfg_wr_en,
  input  logic [vmar_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [vmar_pkg::FIELD_W-1:0]         cfg_wr_data,
  input  logic [2:0]                           in_req_type,
  input  logic [vmar_pkg::FIELD_W-1:0]         in_page,
  input  logic [vmar_pkg::FIELD_W-1:0]         in_npages,
  input  logic                                 in_search_dir,
  input  logic [2:0]                           in_prot_bits,
  input  logic [1:0]                           in_map_flags,
  input  logic [vmar_pkg::FIELD_W-1:0]         in_offset_pages,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           out_status,
  output logic [vmar_pkg::FIELD_W-1:0]         out_page_result,
  output logic [vmar_pkg::FIELD_W-1:0]         out_area_end,
  output logic [vmar_pkg::FIELD_W-1:0]         out_area_offset,
  output logic [2:0]                           out_area_prot,
  output logic                                 out_area_shared,
  output logic                                 out_range_empty
);

  localparam int PW    = PAGE_NUM_BITS;
  localparam int FW    = vmar_pkg::FIELD_W;
  localparam int IW    = $clog2(MAX_AREAS);
  localparam int CW    = $clog2(MAX_AREAS + 1);
  localparam int DEPTH = 2 ** (IW + 1);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_AREAS);
  localparam logic [PW+FW-1:0] LOW_RST_W  = {{PW{1'b0}}, vmar_pkg::USER_LOW_RST};
  localparam logic [PW+FW-1:0] HIGH_RST_W = {{PW{1'b0}}, vmar_pkg::USER_HIGH_RST};

  typedef struct packed {
    logic [PW-1:0] s;
    logic [PW-1:0] e;
    logic [PW-1:0] o;
    logic [2:0]    p;
    logic          sh;
  } ent_t;

  function automatic logic [PW-1:0] to_pw(input logic [FW-1:0] x);
    logic [FW+PW-1:0] t;
    t = {{PW{1'b0}}, x};
    return t[PW-1:0];
  endfunction

  function automatic logic [FW-1:0] to_fw(input logic [PW-1:0] x);
    logic [FW+PW-1:0] t;
    t = {{FW{1'b0}}, x};
    return t[FW-1:0];
  endfunction

  function automatic logic fit(input logic [PW-1:0] a, input logic [PW-1:0] b,
                               input logic [PW-1:0] n);
    return (a > b) && ((a - b) >= n);
  endfunction

  ent_t mem_q [DEPTH];
  ent_t rd_q;

  logic            act_r, dst_r;
  logic [CW-1:0]   cnt_r, ncnt_r, scnt_r, k_r;
  logic            ph_r, ins_done_r, hit_r;
  logic [PW-1:0]   cur_r, start_r;
  vmar_pkg::mode_t mode_r;
  logic [2:0]      typ_r, prot_r;
  logic [1:0]      flg_r;
  logic            dir_r, far_r;
  logic [PW-1:0]   page_r, np_r, hi_r, off_r;
  logic [PW-1:0]   low_r, high_r;
  ent_t            lk_r;

  logic [PW:0]     sum;
  logic [CW-1:0]   k_rev;
  logic [IW-1:0]   rd_idx;
  logic            src;
  logic [PW-1:0]   lim_up, lim_dn, gap_start, tail_start;
  logic            gap_hit, tail_hit, ovl_hit, look_hit;
  logic            outside, need_a, need_b, push_en, full_n, ins_new, we;
  ent_t            tail_ent, push_ent, new_ent, wdata;
  logic            ex_hit, ex_more;

  logic [1:0]      res_status;
  logic [FW-1:0]   res_page, res_end, res_off;
  logic [2:0]      res_prot;
  logic            res_sh, res_empty;

  assign sum   = {1'b0, to_pw(in_page)} + {1'b0, to_pw(in_npages)};
  assign src   = ~dst_r;
  assign k_rev = scnt_r - k_r - CW'(1);
  assign rd_idx = (mode_r == vmar_pkg::M_GAP && dir_r) ? k_rev[IW-1:0] : k_r[IW-1:0];

  assign lim_up     = (rd_q.s < high_r) ? rd_q.s : high_r;
  assign lim_dn     = (rd_q.e > low_r) ? rd_q.e : low_r;
  assign gap_hit    = dir_r ? fit(cur_r, lim_dn, np_r) : fit(lim_up, cur_r, np_r);
  assign tail_hit   = dir_r ? fit(cur_r, low_r, np_r) : fit(high_r, cur_r, np_r);
  assign gap_start  = dir_r ? (cur_r - np_r) : cur_r;
  assign tail_start = gap_start;
  assign ovl_hit    = (rd_q.s < hi_r) && (rd_q.e > page_r);
  assign look_hit   = (rd_q.s <= page_r) && (rd_q.e > page_r);

  assign outside = (rd_q.e <= page_r) || (rd_q.s >= hi_r);
  assign need_a  = !outside && (rd_q.s < page_r);
  assign need_b  = !outside && (rd_q.e > hi_r);
  assign push_en = ph_r || outside || need_a || need_b;
  assign full_n  = (ncnt_r == MAX_C);

  always_comb begin
    tail_ent   = rd_q;
    tail_ent.s = hi_r;
    tail_ent.o = rd_q.o + (hi_r - rd_q.s);
    if (ph_r || !(outside || need_a)) begin
      push_ent = tail_ent;
    end else if (outside) begin
      push_ent = rd_q;
    end else begin
      push_ent   = rd_q;
      push_ent.e = page_r;
    end
  end

  assign new_ent = '{s: start_r, e: start_r + np_r, o: off_r, p: prot_r, sh: flg_r[0]};
  assign ins_new = !ins_done_r && ((k_r == scnt_r) || (rd_q.s > start_r));

  always_comb begin
    ex_hit = 1'b0;
    case (mode_r)
      vmar_pkg::M_GAP:  ex_hit = gap_hit;
      vmar_pkg::M_OVL:  ex_hit = ovl_hit;
      vmar_pkg::M_LOOK: ex_hit = look_hit;
      vmar_pkg::M_CUT:  ex_hit = push_en && full_n;
      default:          ex_hit = 1'b0;
    endcase
  end

  assign ex_more = (mode_r == vmar_pkg::M_CUT) && !ph_r && need_a && need_b && !full_n;
  assign we = cmd.ex && (((mode_r == vmar_pkg::M_CUT) && push_en && !full_n) ||
                         (mode_r == vmar_pkg::M_INS));
  assign wdata = (mode_r == vmar_pkg::M_CUT) ? push_ent : (ins_new ? new_ent : rd_q);

  always_comb begin
    res_status = vmar_pkg::ST_OK;
    res_page   = '0;
    res_end    = '0;
    res_off    = '0;
    res_prot   = '0;
    res_sh     = 1'b0;
    res_empty  = 1'b0;
    case (cmd.kind)
      vmar_pkg::K_ST1: res_status = vmar_pkg::ST_NO_FIT;
      vmar_pkg::K_ST2: res_status = vmar_pkg::ST_FULL;
      vmar_pkg::K_ST3: res_status = vmar_pkg::ST_UNMAPPED;
      vmar_pkg::K_FOUND: res_page = to_fw(start_r);
      vmar_pkg::K_MAP: begin
        res_page = to_fw(start_r);
        res_end  = to_fw(start_r + np_r);
        res_off  = to_fw(off_r);
        res_prot = prot_r;
        res_sh   = flg_r[0];
      end
      vmar_pkg::K_LOOK: begin
        res_page = to_fw(lk_r.s);
        res_end  = to_fw(lk_r.e);
        res_off  = to_fw(lk_r.o);
        res_prot = lk_r.p;
        res_sh   = lk_r.sh;
      end
      vmar_pkg::K_EMPTY: res_empty = (np_r == '0) || !hit_r;
      default: res_status = vmar_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_q <= mem_q[{src, rd_idx}];
    if (we) mem_q[{dst_r, ncnt_r[IW-1:0]}] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r     <= 1'b0;
      cnt_r     <= '0;
      out_valid <= 1'b0;
      low_r     <= LOW_RST_W[PW-1:0];
      high_r    <= HIGH_RST_W[PW-1:0];
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == vmar_pkg::CFG_USER_LOW) low_r <= to_pw(cfg_wr_data);
        if (cfg_index == vmar_pkg::CFG_USER_HIGH) high_r <= to_pw(cfg_wr_data);
      end
      if (cmd.commit) begin
        act_r <= dst_r;
        cnt_r <= ncnt_r;
      end
      if (cmd.deliver) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      typ_r   <= in_req_type;
      page_r  <= to_pw(in_page);
      np_r    <= to_pw(in_npages);
      dir_r   <= in_search_dir;
      prot_r  <= in_prot_bits;
      flg_r   <= in_map_flags;
      off_r   <= to_pw(in_offset_pages);
      start_r <= to_pw(in_page);
      far_r   <= sum[PW];
      hi_r    <= sum[PW] ? '1 : sum[PW-1:0];
      hit_r   <= 1'b0;
    end
    if (cmd.scan) begin
      mode_r     <= cmd.mode;
      k_r        <= '0;
      ncnt_r     <= '0;
      ph_r       <= 1'b0;
      ins_done_r <= 1'b0;
      hit_r      <= 1'b0;
      cur_r      <= dir_r ? high_r : low_r;
      if (cmd.from_scr) begin
        dst_r  <= ~dst_r;
        scnt_r <= ncnt_r;
      end else begin
        dst_r  <= ~act_r;
        scnt_r <= cnt_r;
      end
    end
    if (cmd.tail && mode_r == vmar_pkg::M_GAP && tail_hit) begin
      hit_r   <= 1'b1;
      start_r <= tail_start;
    end
    if (cmd.ex) begin
      case (mode_r)
        vmar_pkg::M_GAP: begin
          if (gap_hit) begin
            hit_r   <= 1'b1;
            start_r <= gap_start;
          end else if (!dir_r && rd_q.e > cur_r) begin
            cur_r <= rd_q.e;
          end else if (dir_r && rd_q.s < cur_r) begin
            cur_r <= rd_q.s;
          end
          k_r <= k_r + CW'(1);
        end
        vmar_pkg::M_OVL: begin
          if (ovl_hit) hit_r <= 1'b1;
          k_r <= k_r + CW'(1);
        end
        vmar_pkg::M_LOOK: begin
          if (look_hit) begin
            hit_r <= 1'b1;
            lk_r  <= rd_q;
          end
          k_r <= k_r + CW'(1);
        end
        vmar_pkg::M_CUT: begin
          if (push_en && full_n) begin
            hit_r <= 1'b1;
          end else begin
            if (push_en) ncnt_r <= ncnt_r + CW'(1);
            if (ex_more) begin
              ph_r <= 1'b1;
            end else begin
              ph_r <= 1'b0;
              k_r  <= k_r + CW'(1);
            end
          end
        end
        default: begin
          ncnt_r <= ncnt_r + CW'(1);
          if (ins_new) ins_done_r <= 1'b1;
          else k_r <= k_r + CW'(1);
        end
      endcase
    end
    if (cmd.deliver) begin
      out_status      <= res_status;
      out_page_result <= res_page;
      out_area_end    <= res_end;
      out_area_offset <= res_off;
      out_area_prot   <= res_prot;
      out_area_shared <= res_sh;
      out_range_empty <= res_empty;
    end
  end

  always_comb begin
    sts           = '0;
    sts.typ       = typ_r;
    sts.mode      = mode_r;
    sts.np_zero   = (np_r == '0);
    sts.page_zero = (page_r == '0);
    sts.fixed     = flg_r[1];
    sts.far       = far_r;
    sts.at_end    = (k_r == scnt_r) && ((mode_r != vmar_pkg::M_INS) || ins_done_r);
    sts.ex_hit    = ex_hit;
    sts.ex_more   = ex_more;
    sts.hit       = hit_r;
    sts.full_act  = (cnt_r == MAX_C);
    sts.full_scr  = full_n;
    sts.out_free  = !out_valid || out_ready;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_C)
    else $error("area count beyond table size");
  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (ncnt_r < MAX_C))
    else $error("table write past last entry");
  a_deliver_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.deliver |=> out_valid)
    else $error("result beat not presented");

endmodule

[sv/vm_area_range_table_top.sv]
// ----------------------------------------------------------------------------
// vm_area_range_table_top
// First-fit page range table: find, map, lookup, remove, range-empty test.
//
// Channels: in_ch carries one request beat, out_ch one result beat per
// request. cfg_wr_en/cfg_index/cfg_wr_data write the user window (index 0
// low page, index 1 high page); the user must do so only while the block
// is idle, which the block itself does not enforce. A table pass reads
// each of the n areas in turn and examines it (states S_RD, S_EX), with a
// second step for each area that a cut splits in two. Lookup, find, remove
// and the empty test use one pass; a searched map a gap pass, and a fixed
// or given-page map a cut or check pass, each followed by an insert pass.
// One request is worked on at a time; the next beat can be taken in the
// cycle after the result is loaded into the output register.
// Reset clears the area count and loads the window defaults; table entries
// are not cleared. A finished result sits in the output register; the next
// request is accepted and processed while it waits, and its own result
// holds until out_ch.ready takes the earlier one.
// ----------------------------------------------------------------------------
module vm_area_range_table_top #(
  parameter int MAX_AREAS     = 16,
  parameter int PAGE_NUM_BITS = 36
) (
  input  logic                           clk,
  input  logic                           rst_n,
  vmar_in_if.sink                        in_ch,
  vmar_out_if.source                     out_ch,
  input  logic                           cfg_wr_en,
  input  logic [vmar_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vmar_pkg::FIELD_W-1:0]   cfg_wr_data
);

  vmar_pkg::cmd_t cmd;
  vmar_pkg::sts_t sts;

  vmar_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  vmar_dp #(
    .MAX_AREAS     (MAX_AREAS),
    .PAGE_NUM_BITS (PAGE_NUM_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wr_data     (cfg_wr_data),
    .in_req_type     (in_ch.req_type),
    .in_page         (in_ch.page),
    .in_npages       (in_ch.npages),
    .in_search_dir   (in_ch.search_dir),
    .in_prot_bits    (in_ch.prot_bits),
    .in_map_flags    (in_ch.map_flags),
    .in_offset_pages (in_ch.offset_pages),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_status      (out_ch.status),
    .out_page_result (out_ch.page_result),
    .out_area_end    (out_ch.area_end),
    .out_area_offset (out_ch.area_offset),
    .out_area_prot   (out_ch.area_prot),
    .out_area_shared (out_ch.area_shared),
    .out_range_empty (out_ch.range_empty)
  );

endmodule

[tb/vmar_tb_if.sv]
// ----------------------------------------------------------------------------
// vmar_tb_if
// Testbench-side note: the request and result channel interfaces come from
// the RTL file vmar_if.sv; this file holds the testbench's shared types.
// ----------------------------------------------------------------------------
package vmar_tb_pkg;
  import vmar_pkg::*;

  typedef struct {
    logic [2:0]  req_type;
    logic [35:0] page;
    logic [35:0] npages;
    logic        search_dir;
    logic [2:0]  prot_bits;
    logic [1:0]  map_flags;
    logic [35:0] offset_pages;
  } request_t;

  typedef struct {
    status_t     status;
    logic [35:0] page_result;
    logic [35:0] area_end;
    logic [35:0] area_offset;
    logic [2:0]  area_prot;
    logic        area_shared;
    logic        range_empty;
  } answer_t;
endpackage

[tb/vmar_checker.sv]
// ----------------------------------------------------------------------------
// vmar_checker
// Watches the request and result channels and the register port, keeps its
// own copy of the area table and window, and compares every result beat with
// the oldest predicted answer.
// ----------------------------------------------------------------------------
module vmar_checker
  import vmar_pkg::*;
  import vmar_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  vmar_in_if          in_ch,
  vmar_out_if         out_ch,
  input  logic        cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FIELD_W-1:0]   cfg_wr_data,
  output int          fail_count,
  output int          pending
);
  localparam int NAREA = 16;
  localparam logic [36:0] PMAX = 37'h0F_FFFF_FFFF;

  logic [35:0] win_low, win_high;
  logic [36:0] a_st[NAREA], a_en[NAREA], a_off[NAREA];
  logic [2:0]  a_prot[NAREA];
  logic        a_sh[NAREA];
  int          a_num;

  logic [36:0] s_st[NAREA], s_en[NAREA], s_off[NAREA];
  logic [2:0]  s_prot[NAREA];
  logic        s_sh[NAREA];
  int          s_num;

  answer_t expected_answers[$];

  function automatic bit push_area(logic [36:0] st, logic [36:0] en, logic [36:0] off,
                                   logic [2:0] p, logic sh);
    if (s_num >= NAREA) return 0;
    s_st[s_num] = st; s_en[s_num] = en; s_off[s_num] = {1'b0, off[35:0]};
    s_prot[s_num] = p; s_sh[s_num] = sh;
    s_num++;
    return 1;
  endfunction

  function automatic void copy_table();
    s_num = 0;
    for (int i = 0; i < a_num; i++)
      void'(push_area(a_st[i], a_en[i], a_off[i], a_prot[i], a_sh[i]));
  endfunction

  function automatic bit cut_range(logic [36:0] lo, logic [36:0] hi);
    s_num = 0;
    for (int i = 0; i < a_num; i++) begin
      if (a_en[i] <= lo || a_st[i] >= hi) begin
        if (!push_area(a_st[i], a_en[i], a_off[i], a_prot[i], a_sh[i])) return 0;
      end else begin
        if (a_st[i] < lo && !push_area(a_st[i], lo, a_off[i], a_prot[i], a_sh[i]))
          return 0;
        if (a_en[i] > hi &&
            !push_area(hi, a_en[i], a_off[i] + (hi - a_st[i]), a_prot[i], a_sh[i]))
          return 0;
      end
    end
    return 1;
  endfunction

  function automatic void commit_table();
    a_st = s_st; a_en = s_en; a_off = s_off; a_prot = s_prot; a_sh = s_sh;
    a_num = s_num;
  endfunction

  function automatic bit any_overlap(logic [36:0] lo, logic [36:0] hi);
    for (int i = 0; i < a_num; i++)
      if (a_st[i] < hi && a_en[i] > lo) return 1;
    return 0;
  endfunction

  function automatic bit first_fit(logic [36:0] np, logic dir, output logic [36:0] found);
    logic [36:0] cur, lim, lw, hg;
    lw = {1'b0, win_low};
    hg = {1'b0, win_high};
    found = '0;
    if (np == 0) return 0;
    if (!dir) begin
      cur = lw;
      for (int i = 0; i < a_num; i++) begin
        lim = a_st[i] < hg ? a_st[i] : hg;
        if (lim > cur && lim - cur >= np) begin found = cur; return 1; end
        if (a_en[i] > cur) cur = a_en[i];
      end
      if (hg > cur && hg - cur >= np) begin found = cur; return 1; end
    end else begin
      cur = hg;
      for (int i = a_num; i > 0; i--) begin
        lim = a_en[i-1] > lw ? a_en[i-1] : lw;
        if (cur > lim && cur - lim >= np) begin found = cur - np; return 1; end
        if (a_st[i-1] < cur) cur = a_st[i-1];
      end
      if (cur > lw && cur - lw >= np) begin found = cur - np; return 1; end
    end
    return 0;
  endfunction

  function automatic answer_t predict_answer(request_t r);
    answer_t a;
    logic [36:0] pg, np, hi, start, fin;
    int k;
    a = '{ST_OK, '0, '0, '0, '0, 1'b0, 1'b0};
    pg = {1'b0, r.page};
    np = {1'b0, r.npages};
    hi = pg + np;
    if (hi > PMAX) hi = PMAX;
    case (r.req_type)
      REQ_FIND: begin
        if (first_fit(np, r.search_dir, start)) a.page_result = start[35:0];
        else a.status = ST_NO_FIT;
      end
      REQ_MAP: begin
        if (np == 0) begin a.status = ST_NO_FIT; return a; end
        if (pg == 0) begin
          if (!first_fit(np, r.search_dir, start)) begin
            a.status = ST_NO_FIT; return a;
          end
          copy_table();
        end else begin
          start = pg;
          if (pg + np > PMAX) begin a.status = ST_NO_FIT; return a; end
          if (r.map_flags[1]) begin
            if (!cut_range(pg, pg + np)) begin a.status = ST_FULL; return a; end
          end else begin
            if (any_overlap(pg, pg + np)) begin a.status = ST_NO_FIT; return a; end
            copy_table();
          end
        end
        if (s_num >= NAREA) begin a.status = ST_FULL; return a; end
        k = s_num;
        while (k > 0 && s_st[k-1] > start) begin
          s_st[k] = s_st[k-1]; s_en[k] = s_en[k-1]; s_off[k] = s_off[k-1];
          s_prot[k] = s_prot[k-1]; s_sh[k] = s_sh[k-1];
          k--;
        end
        fin = start + np;
        s_st[k] = start; s_en[k] = fin; s_off[k] = {1'b0, r.offset_pages};
        s_prot[k] = r.prot_bits; s_sh[k] = r.map_flags[0];
        s_num++;
        commit_table();
        a.page_result = start[35:0];
        a.area_end = fin[35:0];
        a.area_offset = r.offset_pages;
        a.area_prot = r.prot_bits;
        a.area_shared = r.map_flags[0];
      end
      REQ_LOOKUP: begin
        for (int i = 0; i < a_num; i++)
          if (a_st[i] <= pg && a_en[i] > pg) begin
            a.page_result = a_st[i][35:0]; a.area_end = a_en[i][35:0];
            a.area_offset = a_off[i][35:0];
            a.area_prot = a_prot[i]; a.area_shared = a_sh[i];
            return a;
          end
        a.status = ST_UNMAPPED;
      end
      REQ_REMOVE: begin
        if (np != 0) begin
          if (!cut_range(pg, hi)) a.status = ST_FULL;
          else commit_table();
        end
      end
      REQ_EMPTY: a.range_empty = (np == 0) || !any_overlap(pg, hi);
      default: ;
    endcase
    return a;
  endfunction

  task automatic report_mismatch(string what, logic [35:0] got, logic [35:0] want);
    $display("%0t: %s mismatch: got %0h expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    answer_t e;
    request_t rq;
    if (!rst_n) begin
      win_low <= USER_LOW_RST;
      win_high <= USER_HIGH_RST;
      a_num = 0;
      fail_count = 0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_USER_LOW) win_low <= cfg_wr_data;
        else win_high <= cfg_wr_data;
      end
      if (in_ch.valid && in_ch.ready) begin
        rq = '{in_ch.req_type, in_ch.page, in_ch.npages, in_ch.search_dir,
               in_ch.prot_bits, in_ch.map_flags, in_ch.offset_pages};
        expected_answers.push_back(predict_answer(rq));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_answers.size() == 0) begin
          $display("%0t: result beat with nothing expected", $time);
          fail_count++;
        end else begin
          e = expected_answers.pop_front();
          if (out_ch.status != e.status)
            report_mismatch("status", 36'(out_ch.status), 36'(e.status));
          if (out_ch.page_result != e.page_result)
            report_mismatch("page_result", out_ch.page_result, e.page_result);
          if (out_ch.area_end != e.area_end)
            report_mismatch("area_end", out_ch.area_end, e.area_end);
          if (out_ch.area_offset != e.area_offset)
            report_mismatch("area_offset", out_ch.area_offset, e.area_offset);
          if (out_ch.area_prot != e.area_prot)
            report_mismatch("area_prot", 36'(out_ch.area_prot), 36'(e.area_prot));
          if (out_ch.area_shared != e.area_shared)
            report_mismatch("area_shared", 36'(out_ch.area_shared), 36'(e.area_shared));
          if (out_ch.range_empty != e.range_empty)
            report_mismatch("range_empty", 36'(out_ch.range_empty), 36'(e.range_empty));
        end
      end
    end
    pending = expected_answers.size();
  end
endmodule

[tb/tb_vm_area_range_table_top.sv]
// ----------------------------------------------------------------------------
// tb_vm_area_range_table_top
// Drives request beats, window writes and result back-pressure into the
// page range table; the checker beside it predicts and compares.
// ----------------------------------------------------------------------------
module tb_vm_area_range_table_top;
  import vmar_pkg::*;
  import vmar_tb_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_wr_en = 0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_USER_LOW;
  logic [FIELD_W-1:0] cfg_wr_data = '0;
  int fail_count, pending;
  int hold_n;
  bit stim_done = 0;
  logic [35:0] w_lo, w_hi;

  vmar_in_if in_ch();
  vmar_out_if out_ch();

  vm_area_range_table_top uut (.clk, .rst_n, .in_ch, .out_ch, .cfg_wr_en,
                               .cfg_index, .cfg_wr_data);
  vmar_checker chk (.clk, .rst_n, .in_ch, .out_ch, .cfg_wr_en, .cfg_index,
                    .cfg_wr_data, .fail_count, .pending);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
  endfunction

  // result side: random back-pressure, with quiet stretches
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 0;
      hold_n = 0;
    end else if (stim_done) begin
      out_ch.ready <= 1;
    end else if (hold_n > 0) begin
      out_ch.ready <= 0;
      hold_n--;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ch.ready <= 0;
      hold_n = gap_len();
    end else begin
      out_ch.ready <= 1;
    end
  end

  task automatic send(logic [2:0] rt, logic [35:0] pg, logic [35:0] np, logic dir,
                      logic [2:0] pr, logic [1:0] fl, logic [35:0] off);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1; in_ch.req_type <= rt; in_ch.page <= pg; in_ch.npages <= np;
    in_ch.search_dir <= dir; in_ch.prot_bits <= pr; in_ch.map_flags <= fl;
    in_ch.offset_pages <= off;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain_and_write(logic [CFG_IDX_W-1:0] idx, logic [35:0] v);
    in_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg_wr_en <= 1; cfg_index <= idx; cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 0;
  endtask

  function automatic logic [35:0] rnd36();
    return {4'($urandom_range(0, 15)), $urandom()};
  endfunction

  task automatic random_item();
    logic [35:0] pg, np, base;
    logic [2:0] rt;
    int sel;
    base = w_lo + 36'($urandom_range(0, 400));
    sel = $urandom_range(0, 99);
    np = (sel < 90) ? 36'($urandom_range(1, 40)) : ((sel < 95) ? 36'd0 : rnd36());
    pg = ($urandom_range(0, 9) < 8) ? base : rnd36();
    rt = $urandom_range(0, 99) < 3 ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    if (rt == REQ_MAP && $urandom_range(0, 3) == 0) pg = 0;
    send(rt, pg, np, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
         2'($urandom_range(0, 3)), rnd36());
  endtask

  initial begin
    in_ch.valid = 0; in_ch.req_type = '0; in_ch.page = '0; in_ch.npages = '0;
    in_ch.search_dir = 0; in_ch.prot_bits = '0; in_ch.map_flags = '0;
    in_ch.offset_pages = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: extremes and special cases
    send(REQ_FIND, 0, 5, 0, 0, 0, 0);
    send(REQ_FIND, 0, 5, 1, 0, 0, 0);
    send(REQ_FIND, 0, 0, 0, 0, 0, 0);
    send(REQ_MAP, 0, 0, 0, 7, 3, '1);
    send(REQ_MAP, 0, 8, 0, 7, 1, '1);
    send(REQ_MAP, 0, 8, 1, 5, 0, 36'd3);
    send(REQ_MAP, 100, 20, 0, 2, 0, 36'd9);
    send(REQ_MAP, 105, 4, 0, 1, 0, 0);
    send(REQ_MAP, '1, 1, 0, 1, 0, 0);
    send(REQ_MAP, 36'hF_FFFF_FFFE, 1, 0, 6, 2, 36'hF_FFFF_FFFF);
    send(REQ_MAP, 105, 4, 0, 3, 2, 36'd1);
    send(REQ_LOOKUP, 100, 0, 0, 0, 0, 0);
    send(REQ_LOOKUP, 110, 0, 0, 0, 0, 0);
    send(REQ_LOOKUP, 0, 0, 0, 0, 0, 0);
    send(REQ_LOOKUP, '1, 0, 0, 0, 0, 0);
    send(REQ_EMPTY, 100, 0, 0, 0, 0, 0);
    send(REQ_EMPTY, 0, '1, 0, 0, 0, 0);
    send(REQ_EMPTY, 200, 10, 0, 0, 0, 0);
    send(REQ_REMOVE, 102, 2, 0, 0, 0, 0);
    send(REQ_REMOVE, 103, 0, 0, 0, 0, 0);
    send(REQ_REMOVE, 0, '1, 0, 0, 0, 0);
    send(3'd5, 0, 0, 0, 0, 0, 0);
    send(3'd7, '1, '1, 1, 7, 3, '1);
    // table full: fill with small areas
    for (int i = 0; i < 18; i++) send(REQ_MAP, 36'(1000 + 4 * i), 2, 0, 0, 0, 36'(i));
    send(REQ_REMOVE, 1000, 1, 0, 0, 0, 0);
    send(REQ_REMOVE, 0, '1, 0, 0, 0, 0);

    // random phases over several windows
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin w_lo = 0; w_hi = '1; end
        1: begin w_lo = 36'd50; w_hi = 36'd300; end
        2: begin w_lo = 36'd400; w_hi = 36'd100; end
        3: begin w_lo = 36'hF_FFFF_FE00; w_hi = '1; end
        4: begin w_lo = rnd36() & 36'hF_FFFF_F000; w_hi = w_lo + 36'd600; end
        default: begin w_lo = USER_LOW_RST; w_hi = USER_HIGH_RST; end
      endcase
      drain_and_write(CFG_USER_LOW, w_lo);
      drain_and_write(CFG_USER_HIGH, w_hi);
      for (int n = 0; n < 180; n++) begin
        random_item();
        if ($urandom_range(0, 60) == 0) send(REQ_REMOVE, 0, '1, 0, 0, 0, 0);
      end
    end

    in_ch.valid <= 0;
    stim_done = 1;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("vm_area_range_table_top regression: pass");
    else $display("vm_area_range_table_top regression: fail");
    $finish;
  end

  initial begin
    #4000000;
    $display("vm_area_range_table_top regression: fail");
    $finish;
  end
endmodule
